// File: design/max_bottleneck_path_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros for the bottleneck path block
// ---------------------------------------------------------------------------
`ifndef MAX_BOTTLENECK_PATH_MACROS_SVH
`define MAX_BOTTLENECK_PATH_MACROS_SVH

// assert that a implies b on the next cycle
`define MBP_ASSERT_NEXT(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("assertion failed");

// assert that a implies b in the same cycle
`define MBP_ASSERT_SAME(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("assertion failed");

`endif

// File: design/mbp_pkg.sv
// ---------------------------------------------------------------------------
// mbp_pkg
// Shared constants for the bottleneck path block.
// ---------------------------------------------------------------------------
package mbp_pkg;
    localparam int unsigned MAX_NODES = 1024;
    localparam int unsigned MAX_EDGES = 4096;
    localparam logic [30:0] SAME_NODE_ANSWER = 31'd2147000000;
    localparam int unsigned NODE_W   = 11;
    localparam int unsigned WEIGHT_W = 31;
    localparam logic [1:0] REG_NODE_COUNT  = 2'd0;
    localparam logic [1:0] REG_SOURCE_NODE = 2'd1;
    localparam logic [1:0] REG_TARGET_NODE = 2'd2;
endpackage

// File: design/mbp_edge_if.sv
// ---------------------------------------------------------------------------
// mbp_edge_if
// Input channel: one weighted edge per item.
// ---------------------------------------------------------------------------
interface mbp_edge_if;
    logic        valid;
    logic        ready;
    logic [10:0] end_a;
    logic [10:0] end_b;
    logic [30:0] weight;
    logic        last_edge;
    modport source (output valid, end_a, end_b, weight, last_edge, input ready);
    modport sink (input valid, end_a, end_b, weight, last_edge, output ready);
endinterface

// File: design/mbp_result_if.sv
// ---------------------------------------------------------------------------
// mbp_result_if
// Output channel: one bottleneck value per item.
// ---------------------------------------------------------------------------
interface mbp_result_if;
    logic        valid;
    logic        ready;
    logic [30:0] bottleneck;
    modport source (output valid, bottleneck, input ready);
    modport sink (input valid, bottleneck, output ready);
endinterface

// File: design/max_bottleneck_path.sv
// ---------------------------------------------------------------------------
// max_bottleneck_path
// Stores edges, then runs Kruskal with union-find to report the bottleneck.
// ---------------------------------------------------------------------------
// Usage: edges arrive on edge_in, one item per cycle while ready is high.
// An item with last_edge set starts the query; ready stays low until the
// result item is taken on result_out and the clearing pass is done.
// Items without last_edge give no result.
// The query selects the heaviest unused edge by a linear scan of the edge
// memory, repeated for each edge it picks, plus root walks in the parent
// memory and a second walk along the same path for path compression.
// The result is valid in the cycle after the query ends.
// After the result a clearing pass rewrites the parent and rank memory,
// entries 0 to MAX_NODES. After reset the same pass runs before the first
// item. Configuration writes through APB take effect at once; write them
// only between graphs.
// While result_out is stalled the result holds and no item is accepted.
// ---------------------------------------------------------------------------
`include "max_bottleneck_path_macros.svh"

module max_bottleneck_path #(
    parameter int unsigned MAX_NODES = mbp_pkg::MAX_NODES,
    parameter int unsigned MAX_EDGES = mbp_pkg::MAX_EDGES
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    mbp_edge_if.sink    edge_in,
    mbp_result_if.source result_out
);
    localparam int unsigned NW = (MAX_NODES < 2) ? 1 : $clog2(MAX_NODES + 1);
    localparam int unsigned EA = (MAX_EDGES < 2) ? 1 : $clog2(MAX_EDGES);
    localparam int unsigned EC = $clog2(MAX_EDGES + 1);
    localparam int unsigned RW = 5;
    localparam int unsigned DW = 2 * NW + 31;
    localparam int unsigned PW = NW + RW;

    localparam logic [3:0] S_CLEAR   = 4'd0;
    localparam logic [3:0] S_IDLE    = 4'd1;
    localparam logic [3:0] S_SCAN    = 4'd2;
    localparam logic [3:0] S_SCANW   = 4'd3;
    localparam logic [3:0] S_PICK    = 4'd4;
    localparam logic [3:0] S_FINDR   = 4'd5;
    localparam logic [3:0] S_FINDW   = 4'd6;
    localparam logic [3:0] S_COMPR   = 4'd8;
    localparam logic [3:0] S_COMPW   = 4'd9;
    localparam logic [3:0] S_COMPC   = 4'd10;
    localparam logic [3:0] S_DECIDE  = 4'd11;
    localparam logic [3:0] S_LINK    = 4'd12;
    localparam logic [3:0] S_OUT     = 4'd13;

    // find jobs
    localparam logic [1:0] J_A = 2'd0;
    localparam logic [1:0] J_B = 2'd1;
    localparam logic [1:0] J_S = 2'd2;
    localparam logic [1:0] J_T = 2'd3;

    logic [10:0] node_count_reg, source_node_reg, target_node_reg;
    logic [3:0]  state_reg, state_next;
    logic [EC-1:0] edge_total_reg, edge_total_next;
    logic [EC-1:0] scan_reg, scan_next;
    logic [EC-1:0] taken_cnt_reg, taken_cnt_next;
    logic [EA-1:0] best_idx_reg, best_idx_next;
    logic [31:0]   best_w_reg, best_w_next;
    logic          best_ok_reg, best_ok_next;
    logic [EC-1:0] used_cnt_reg, used_cnt_next;
    logic [NW-1:0] clr_reg, clr_next;
    logic [NW-1:0] cur_reg, cur_next;
    logic [NW-1:0] start_reg, start_next;
    logic [NW-1:0] root_reg, root_next;
    logic [NW-1:0] ra_reg, ra_next, rb_reg, rb_next;
    logic [RW-1:0] rka_reg, rka_next, rkb_reg, rkb_next;
    logic [1:0]    job_reg, job_next;
    logic [NW-1:0] ea_reg, ea_next, eb_reg, eb_next;
    logic [30:0]   ew_reg, ew_next;
    logic [30:0]   res_reg, res_next;
    logic          res_valid_reg, res_valid_next;
    logic [NW:0]   nc_eff;
    logic [10:0]   nc11;
    logic          in_acc, a_ok, b_ok, store_ok;
    logic          used_we;
    logic [EA-1:0] used_addr;
    logic          used_wdata, used_rdata;

    logic          e_we;
    logic [EA-1:0] e_addr;
    logic [DW-1:0] e_wdata, e_rdata;
    logic          p_we;
    logic [NW-1:0] p_addr;
    logic [PW-1:0] p_wdata, p_rdata;
    logic [NW-1:0] p_par;
    logic [RW-1:0] p_rank;

    assign pready = 1'b1;

    always_comb
    begin
        unique case (paddr[3:2])
            mbp_pkg::REG_NODE_COUNT:  prdata = {21'd0, node_count_reg};
            mbp_pkg::REG_SOURCE_NODE: prdata = {21'd0, source_node_reg};
            mbp_pkg::REG_TARGET_NODE: prdata = {21'd0, target_node_reg};
            default:                  prdata = 32'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            node_count_reg  <= 11'd1024;
            source_node_reg <= 11'd1;
            target_node_reg <= 11'd1;
        end
        else if (psel && penable && pwrite)
        begin
            unique case (paddr[3:2])
                mbp_pkg::REG_NODE_COUNT:  node_count_reg  <= pwdata[10:0];
                mbp_pkg::REG_SOURCE_NODE: source_node_reg <= pwdata[10:0];
                mbp_pkg::REG_TARGET_NODE: target_node_reg <= pwdata[10:0];
                default:                  ;
            endcase
        end
    end

    assign nc11 = (node_count_reg == 11'd0) ? 11'd1 : node_count_reg;
    assign nc_eff = ({21'd0, nc11} > MAX_NODES) ? (NW+1)'(MAX_NODES) : (NW+1)'(nc11);

    function automatic logic node_ok(input logic [10:0] n, input logic [NW:0] nc);
        logic [31:0] n32;
        n32 = {21'd0, n};
        node_ok = (n != 11'd0) && (n32 <= {{(31-NW){1'b0}}, nc});
    endfunction

    assign edge_in.ready = (state_reg == S_IDLE);
    assign in_acc = edge_in.valid && edge_in.ready;
    assign a_ok = node_ok(edge_in.end_a, nc_eff);
    assign b_ok = node_ok(edge_in.end_b, nc_eff);
    assign store_ok = a_ok && b_ok && ({{(32-EC){1'b0}}, edge_total_reg} < MAX_EDGES);

    assign result_out.valid = res_valid_reg;
    assign result_out.bottleneck = res_reg;

    assign {p_par, p_rank} = p_rdata;

    mbp_ram #(.WIDTH(DW), .DEPTH(1 << EA)) u_edges (
        .clk(clk), .we(e_we), .addr(e_addr), .wdata(e_wdata), .rdata(e_rdata));
    mbp_ram #(.WIDTH(1), .DEPTH(1 << EA)) u_used (
        .clk(clk), .we(used_we), .addr(used_addr), .wdata(used_wdata),
        .rdata(used_rdata));
    mbp_ram #(.WIDTH(PW), .DEPTH(1 << NW)) u_sets (
        .clk(clk), .we(p_we), .addr(p_addr), .wdata(p_wdata), .rdata(p_rdata));

    always_comb
    begin
        state_next      = state_reg;
        edge_total_next = edge_total_reg;
        scan_next       = scan_reg;
        taken_cnt_next  = taken_cnt_reg;
        best_idx_next   = best_idx_reg;
        best_w_next     = best_w_reg;
        best_ok_next    = best_ok_reg;
        used_cnt_next   = used_cnt_reg;
        clr_next        = clr_reg;
        cur_next        = cur_reg;
        start_next      = start_reg;
        root_next       = root_reg;
        ra_next         = ra_reg;
        rb_next         = rb_reg;
        rka_next        = rka_reg;
        rkb_next        = rkb_reg;
        job_next        = job_reg;
        ea_next         = ea_reg;
        eb_next         = eb_reg;
        ew_next         = ew_reg;
        res_next        = res_reg;
        res_valid_next  = res_valid_reg;
        e_we            = 1'b0;
        e_addr          = scan_reg[EA-1:0];
        e_wdata         = {NW'(edge_in.end_a), NW'(edge_in.end_b), edge_in.weight};
        used_we         = 1'b0;
        used_addr       = scan_reg[EA-1:0];
        used_wdata      = 1'b0;
        p_we            = 1'b0;
        p_addr          = cur_reg;
        p_wdata         = {clr_reg, RW'(1)};

        unique case (state_reg)
            S_CLEAR:
            begin
                p_we = 1'b1;
                p_addr = clr_reg;
                p_wdata = {clr_reg, RW'(1)};
                if (clr_reg == NW'(MAX_NODES))
                begin
                    clr_next = '0;
                    used_cnt_next = '0;
                    state_next = S_IDLE;
                end
                else
                begin
                    clr_next = clr_reg + NW'(1);
                end
            end
            S_IDLE:
            begin
                e_addr = edge_total_reg[EA-1:0];
                used_addr = edge_total_reg[EA-1:0];
                if (in_acc)
                begin
                    if (store_ok)
                    begin
                        e_we = 1'b1;
                        used_we = 1'b1;
                        edge_total_next = edge_total_reg + EC'(1);
                    end
                    if (edge_in.last_edge)
                    begin
                        if (source_node_reg == target_node_reg)
                        begin
                            res_next = mbp_pkg::SAME_NODE_ANSWER;
                            state_next = S_OUT;
                        end
                        else if (!node_ok(source_node_reg, nc_eff) ||
                                 !node_ok(target_node_reg, nc_eff))
                        begin
                            res_next = '0;
                            state_next = S_OUT;
                        end
                        else
                        begin
                            scan_next = '0;
                            best_ok_next = 1'b0;
                            state_next = S_SCAN;
                        end
                    end
                end
            end
            S_SCAN:
            begin
                if (scan_reg == edge_total_reg)
                begin
                    state_next = S_PICK;
                end
                else
                begin
                    e_addr = scan_reg[EA-1:0];
                    used_addr = scan_reg[EA-1:0];
                    state_next = S_SCANW;
                end
            end
            S_SCANW:
            begin
                used_addr = scan_reg[EA-1:0];
                e_addr = scan_reg[EA-1:0];
                if (!used_rdata &&
                    (!best_ok_reg || {1'b0, e_rdata[30:0]} > best_w_reg))
                begin
                    best_ok_next = 1'b1;
                    best_w_next = {1'b0, e_rdata[30:0]};
                    best_idx_next = scan_reg[EA-1:0];
                    ea_next = e_rdata[DW-1 -: NW];
                    eb_next = e_rdata[30 + NW -: NW];
                    ew_next = e_rdata[30:0];
                end
                scan_next = scan_reg + EC'(1);
                state_next = S_SCAN;
            end
            S_PICK:
            begin
                if (!best_ok_reg)
                begin
                    res_next = '0;
                    state_next = S_OUT;
                end
                else
                begin
                    used_we = 1'b1;
                    used_addr = best_idx_reg;
                    used_wdata = 1'b1;
                    used_cnt_next = used_cnt_reg + EC'(1);
                    // drop edges whose endpoints left the node range
                    if (!node_ok(11'(ea_reg), nc_eff) || !node_ok(11'(eb_reg), nc_eff))
                    begin
                        scan_next = '0;
                        best_ok_next = 1'b0;
                        state_next = S_SCAN;
                    end
                    else
                    begin
                        job_next = J_A;
                        cur_next = ea_reg;
                        start_next = ea_reg;
                        state_next = S_FINDR;
                    end
                end
            end
            S_FINDR:
            begin
                p_addr = cur_reg;
                state_next = S_FINDW;
            end
            S_FINDW:
            begin
                p_addr = cur_reg;
                if (p_par == cur_reg)
                begin
                    root_next = cur_reg;
                    if (job_reg == J_A || job_reg == J_S)
                    begin
                        rka_next = p_rank;
                    end
                    else
                    begin
                        rkb_next = p_rank;
                    end
                    cur_next = start_reg;
                    state_next = S_COMPR;
                end
                else
                begin
                    cur_next = p_par;
                    state_next = S_FINDR;
                end
            end
            S_COMPR:
            begin
                p_addr = cur_reg;
                state_next = S_COMPW;
            end
            S_COMPW:
            begin
                p_addr = cur_reg;
                if (cur_reg == root_reg || p_par == root_reg)
                begin
                    state_next = S_COMPC;
                end
                else
                begin
                    p_we = 1'b1;
                    p_wdata = {root_reg, p_rank};
                    cur_next = p_par;
                    state_next = S_COMPR;
                end
            end
            S_COMPC:
            begin
                unique case (job_reg)
                    J_A:
                    begin
                        ra_next = root_reg;
                        job_next = J_B;
                        cur_next = eb_reg;
                        start_next = eb_reg;
                        state_next = S_FINDR;
                    end
                    J_B:
                    begin
                        rb_next = root_reg;
                        state_next = S_DECIDE;
                    end
                    J_S:
                    begin
                        ra_next = root_reg;
                        job_next = J_T;
                        cur_next = NW'(target_node_reg);
                        start_next = NW'(target_node_reg);
                        state_next = S_FINDR;
                    end
                    default:
                    begin
                        if (ra_reg == root_reg)
                        begin
                            res_next = ew_reg;
                            state_next = S_OUT;
                        end
                        else
                        begin
                            scan_next = '0;
                            best_ok_next = 1'b0;
                            state_next = S_SCAN;
                        end
                    end
                endcase
            end
            S_DECIDE:
            begin
                if (ra_reg == rb_reg)
                begin
                    scan_next = '0;
                    best_ok_next = 1'b0;
                    state_next = S_SCAN;
                end
                else if ({{(32-EC){1'b0}}, taken_cnt_reg} ==
                         {{(31-NW){1'b0}}, nc_eff} - 32'd1)
                begin
                    res_next = '0;
                    state_next = S_OUT;
                end
                else
                begin
                    taken_cnt_next = taken_cnt_reg + EC'(1);
                    p_we = 1'b1;
                    if (rka_reg > rkb_reg)
                    begin
                        p_addr = rb_reg;
                        p_wdata = {ra_reg, rkb_reg};
                    end
                    else
                    begin
                        p_addr = ra_reg;
                        p_wdata = {rb_reg, rka_reg};
                    end
                    state_next = S_LINK;
                end
            end
            S_LINK:
            begin
                p_we = (rka_reg == rkb_reg);
                p_addr = rb_reg;
                p_wdata = {rb_reg, rkb_reg + RW'(1)};
                job_next = J_S;
                cur_next = NW'(source_node_reg);
                start_next = NW'(source_node_reg);
                state_next = S_FINDR;
            end
            S_OUT:
            begin
                res_valid_next = 1'b1;
                if (res_valid_reg && result_out.ready)
                begin
                    res_valid_next = 1'b0;
                    edge_total_next = '0;
                    taken_cnt_next = '0;
                    clr_next = '0;
                    state_next = S_CLEAR;
                end
            end
            default:
            begin
                state_next = S_CLEAR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_CLEAR;
            edge_total_reg <= '0;
            taken_cnt_reg  <= '0;
            clr_reg        <= '0;
            res_valid_reg  <= 1'b0;
            scan_reg       <= '0;
            best_ok_reg    <= 1'b0;
            used_cnt_reg   <= '0;
            job_reg        <= J_A;
        end
        else
        begin
            state_reg      <= state_next;
            edge_total_reg <= edge_total_next;
            taken_cnt_reg  <= taken_cnt_next;
            clr_reg        <= clr_next;
            res_valid_reg  <= res_valid_next;
            scan_reg       <= scan_next;
            best_ok_reg    <= best_ok_next;
            used_cnt_reg   <= used_cnt_next;
            job_reg        <= job_next;
        end
    end

    always_ff @(posedge clk)
    begin
        best_idx_reg <= best_idx_next;
        best_w_reg   <= best_w_next;
        cur_reg      <= cur_next;
        start_reg    <= start_next;
        root_reg     <= root_next;
        ra_reg       <= ra_next;
        rb_reg       <= rb_next;
        rka_reg      <= rka_next;
        rkb_reg      <= rkb_next;
        ea_reg       <= ea_next;
        eb_reg       <= eb_next;
        ew_reg       <= ew_next;
        res_reg      <= res_next;
    end

    `MBP_ASSERT_SAME(a_ready_idle, clk, rst_n, edge_in.ready, !res_valid_reg)
    `MBP_ASSERT_NEXT(a_hold, clk, rst_n, res_valid_reg && !result_out.ready,
        res_valid_reg && $stable(res_reg))
    `MBP_ASSERT_SAME(a_used_bound, clk, rst_n, state_reg == S_PICK,
        used_cnt_reg <= edge_total_reg)
endmodule

// File: design/mbp_ram.sv
// ---------------------------------------------------------------------------
// mbp_ram
// Single port RAM with registered read.
// ---------------------------------------------------------------------------
module mbp_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule

// File: test/tb.sv
// ---------------------------------------------------------------------------
// tb
// Feeds weighted edge lists into the bottleneck path block and checks each
// reported bottleneck against a union-find model of the maximum spanning
// forest. Random gaps on both channels, one long output stall, and register
// changes between graphs.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
    localparam int CLEAR_WAIT = mbp_pkg::MAX_NODES + 200;
    localparam logic [1:0]  R_NODES = mbp_pkg::REG_NODE_COUNT;
    localparam logic [1:0]  R_SRC   = mbp_pkg::REG_SOURCE_NODE;
    localparam logic [1:0]  R_TGT   = mbp_pkg::REG_TARGET_NODE;
    localparam logic [30:0] SAME    = mbp_pkg::SAME_NODE_ANSWER;

    typedef enum logic {ROW_CFG, ROW_EDGE} row_kind_t;

    typedef struct {
        row_kind_t   kind;
        logic [1:0]  reg_idx;
        logic [10:0] a;
        logic [10:0] b;
        logic [30:0] w;
        logic        lst;
        bit          fixed;
        logic [30:0] fixed_val;
    } stim_row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [3:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    logic        rand_ready = 1'b0;
    logic        long_hold = 1'b0;
    logic        item_fixed = 1'b0;
    logic [30:0] item_fixed_val = '0;
    bit          idle_free = 1'b0;

    logic [10:0] cfg_nodes = 11'd1024;
    logic [10:0] cfg_src = 11'd1;
    logic [10:0] cfg_tgt = 11'd1;

    logic [10:0] graph_a[$];
    logic [10:0] graph_b[$];
    logic [30:0] graph_w[$];
    logic [30:0] pending_bottleneck[$];
    int          mismatches = 0;

    mbp_edge_if   edge_ch();
    mbp_result_if res_ch();

    assign res_ch.ready = rand_ready && !long_hold;

    max_bottleneck_path u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .edge_in    (edge_ch.sink),
        .result_out (res_ch.source)
    );

    always #5 clk = ~clk;

    initial
    begin
        edge_ch.valid = 1'b0;
        edge_ch.end_a = '0;
        edge_ch.end_b = '0;
        edge_ch.weight = '0;
        edge_ch.last_edge = 1'b0;
    end

    initial
    begin
        #100ms;
        $display("tb failed");
        $finish;
    end

    function automatic int live_nodes();
        if (cfg_nodes == 0) return 1;
        if (cfg_nodes > mbp_pkg::MAX_NODES) return mbp_pkg::MAX_NODES;
        return int'(cfg_nodes);
    endfunction

    function automatic int find_root(ref int parent[mbp_pkg::MAX_NODES + 1], input int x);
        while (parent[x] != x) x = parent[x];
        return x;
    endfunction

    function automatic logic [30:0] widest_path();
        int   parent[mbp_pkg::MAX_NODES + 1];
        bit   taken_flag[mbp_pkg::MAX_EDGES];
        int   nc;
        int   s;
        int   t;
        int   taken;
        int   best;
        int   ra;
        int   rb;
        nc = live_nodes();
        s = int'(cfg_src);
        t = int'(cfg_tgt);
        if (s == t) return SAME;
        if (s == 0 || s > nc || t == 0 || t > nc) return '0;
        for (int i = 0; i <= mbp_pkg::MAX_NODES; i++) parent[i] = i;
        foreach (taken_flag[i]) taken_flag[i] = 1'b0;
        taken = 0;
        for (int n = 0; n < graph_w.size(); n++)
        begin
            best = -1;
            foreach (graph_w[i])
                if (!taken_flag[i] && (best < 0 || graph_w[i] > graph_w[best])) best = i;
            taken_flag[best] = 1'b1;
            if (graph_a[best] == 0 || graph_a[best] > nc ||
                graph_b[best] == 0 || graph_b[best] > nc) continue;
            ra = find_root(parent, int'(graph_a[best]));
            rb = find_root(parent, int'(graph_b[best]));
            if (ra == rb) continue;
            if (taken == nc - 1) break;
            taken++;
            parent[ra] = rb;
            if (find_root(parent, s) == find_root(parent, t)) return graph_w[best];
        end
        return '0;
    endfunction

    always @(posedge clk)
    begin
        int nc;
        logic [30:0] answer;
        if (edge_ch.valid && edge_ch.ready)
        begin
            nc = live_nodes();
            if (edge_ch.end_a != 0 && edge_ch.end_a <= nc && edge_ch.end_b != 0 &&
                edge_ch.end_b <= nc && graph_w.size() < mbp_pkg::MAX_EDGES)
            begin
                graph_a = {graph_a, edge_ch.end_a};
                graph_b = {graph_b, edge_ch.end_b};
                graph_w = {graph_w, edge_ch.weight};
            end
            if (edge_ch.last_edge)
            begin
                answer = widest_path();
                pending_bottleneck = {pending_bottleneck,
                                      (item_fixed ? item_fixed_val : answer)};
                graph_a.delete();
                graph_b.delete();
                graph_w.delete();
            end
        end
    end

    always @(posedge clk)
    begin
        logic [30:0] want;
        if (res_ch.valid && res_ch.ready)
        begin
            if (pending_bottleneck.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: bottleneck=%0d", res_ch.bottleneck);
            end
            else
            begin
                want = pending_bottleneck.pop_front();
                if (res_ch.bottleneck !== want)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("bottleneck mismatch: expected %0d, got %0d",
                                 want, res_ch.bottleneck);
                end
            end
        end
    end

    initial
    begin
        int len;
        wait (rst_n);
        forever
        begin
            rand_ready <= 1'b1;
            repeat ($urandom_range(1, 40)) @(posedge clk);
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 80) : $urandom_range(0, 3);
            if (len > 0)
            begin
                rand_ready <= 1'b0;
                repeat (len) @(posedge clk);
            end
        end
    end

    initial
    begin
        wait (rst_n);
        repeat (30000) @(posedge clk);
        long_hold <= 1'b1;
        repeat (4000) @(posedge clk);
        long_hold <= 1'b0;
    end

    task automatic send_edge(input logic [10:0] a, input logic [10:0] b,
                             input logic [30:0] w, input logic lst,
                             input bit fixed, input logic [30:0] fixed_val);
        int gap;
        gap = 0;
        if (!idle_free)
            gap = ($urandom_range(0, 15) == 0) ? $urandom_range(10, 60) : $urandom_range(0, 2);
        if (gap > 0)
        begin
            edge_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        edge_ch.valid <= 1'b1;
        edge_ch.end_a <= a;
        edge_ch.end_b <= b;
        edge_ch.weight <= w;
        edge_ch.last_edge <= lst;
        item_fixed <= fixed;
        item_fixed_val <= fixed_val;
        do @(posedge clk); while (!edge_ch.ready);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [10:0] value);
        edge_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending_bottleneck.size() != 0) @(posedge clk);
        repeat (CLEAR_WAIT) @(posedge clk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= {21'd0, value};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            R_NODES: cfg_nodes = value;
            R_SRC:   cfg_src = value;
            R_TGT:   cfg_tgt = value;
            default: ;
        endcase
    endtask

    function automatic logic [10:0] pick_node(input int nc);
        if ($urandom_range(0, 19) == 0) return 11'($urandom_range(0, 2047));
        return 11'($urandom_range(1, nc));
    endfunction

    stim_row_t directed[$] = '{
        '{ROW_EDGE, R_NODES, 11'd1, 11'd2, 31'd5, 1'b1, 1'b1, SAME},
        '{ROW_CFG, R_NODES, 11'd4, '0, '0, 1'b0, 1'b0, '0},
        '{ROW_CFG, R_TGT, 11'd2, '0, '0, 1'b0, 1'b0, '0},
        '{ROW_EDGE, R_NODES, 11'd1, 11'd2, 31'd100, 1'b1, 1'b1, 31'd100},
        '{ROW_EDGE, R_NODES, 11'd2, 11'd1, 31'h7FFFFFFF, 1'b1, 1'b1, 31'h7FFFFFFF},
        '{ROW_EDGE, R_NODES, 11'd1, 11'd2, 31'd0, 1'b1, 1'b1, 31'd0},
        '{ROW_EDGE, R_NODES, 11'd0, 11'd2, 31'd9, 1'b1, 1'b1, 31'd0},
        '{ROW_EDGE, R_NODES, 11'd1, 11'd2047, 31'd9, 1'b1, 1'b1, 31'd0},
        '{ROW_EDGE, R_NODES, 11'd1, 11'd3, 31'd40, 1'b0, 1'b0, '0},
        '{ROW_EDGE, R_NODES, 11'd3, 11'd2, 31'd70, 1'b0, 1'b0, '0},
        '{ROW_EDGE, R_NODES, 11'd1, 11'd2, 31'd10, 1'b0, 1'b0, '0},
        '{ROW_EDGE, R_NODES, 11'd4, 11'd4, 31'd70, 1'b1, 1'b1, 31'd40},
        '{ROW_EDGE, R_NODES, 11'd1, 11'd3, 31'd7, 1'b0, 1'b0, '0},
        '{ROW_EDGE, R_NODES, 11'd3, 11'd2, 31'd7, 1'b0, 1'b0, '0},
        '{ROW_EDGE, R_NODES, 11'd1, 11'd2, 31'd7, 1'b1, 1'b0, '0},
        '{ROW_CFG, R_TGT, 11'd5, '0, '0, 1'b0, 1'b0, '0},
        '{ROW_EDGE, R_NODES, 11'd1, 11'd2, 31'd3, 1'b1, 1'b1, 31'd0},
        '{ROW_CFG, R_SRC, 11'd2047, '0, '0, 1'b0, 1'b0, '0},
        '{ROW_CFG, R_TGT, 11'd2047, '0, '0, 1'b0, 1'b0, '0},
        '{ROW_EDGE, R_NODES, 11'd1, 11'd2, 31'd3, 1'b1, 1'b1, SAME},
        '{ROW_CFG, R_NODES, 11'd0, '0, '0, 1'b0, 1'b0, '0},
        '{ROW_CFG, R_SRC, 11'd0, '0, '0, 1'b0, 1'b0, '0},
        '{ROW_CFG, R_TGT, 11'd1, '0, '0, 1'b0, 1'b0, '0},
        '{ROW_EDGE, R_NODES, 11'd1, 11'd1, 31'd3, 1'b1, 1'b1, 31'd0},
        '{ROW_CFG, R_NODES, 11'd2047, '0, '0, 1'b0, 1'b0, '0},
        '{ROW_CFG, R_SRC, 11'd1024, '0, '0, 1'b0, 1'b0, '0},
        '{ROW_EDGE, R_NODES, 11'd1024, 11'd1, 31'd55, 1'b1, 1'b1, 31'd55}
    };

    initial
    begin
        int sent;
        int nc;
        int edges;
        int wmode;
        logic [30:0] w;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        foreach (directed[i])
        begin
            if (directed[i].kind == ROW_CFG)
                write_reg(directed[i].reg_idx, directed[i].a);
            else
                send_edge(directed[i].a, directed[i].b, directed[i].w, directed[i].lst,
                          directed[i].fixed, directed[i].fixed_val);
        end
        sent = 0;
        while (sent < 630)
        begin
            if ($urandom_range(0, 3) == 0)
            begin
                case ($urandom_range(0, 9))
                    0: nc = 1024;
                    1: nc = 2;
                    2: nc = 1;
                    default: nc = $urandom_range(3, 14);
                endcase
                write_reg(R_NODES, ($urandom_range(0, 19) == 0) ? 11'd2047 : 11'(nc));
                write_reg(R_SRC, pick_node(live_nodes()));
                write_reg(R_TGT, ($urandom_range(0, 9) == 0) ? cfg_src :
                          pick_node(live_nodes()));
                idle_free = ($urandom_range(0, 3) == 0);
            end
            nc = live_nodes();
            edges = ($urandom_range(0, 19) == 0) ? $urandom_range(30, 60) :
                    $urandom_range(1, 12);
            wmode = $urandom_range(0, 3);
            for (int k = 0; k < edges; k++)
            begin
                case (wmode)
                    0: w = 31'($urandom_range(0, 7));
                    1: w = ($urandom_range(0, 1) == 1) ? 31'h7FFFFFFF : 31'd0;
                    default: w = 31'($urandom());
                endcase
                send_edge(pick_node(nc), pick_node(nc), w, k == edges - 1, 1'b0, '0);
                sent++;
            end
        end
        edge_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending_bottleneck.size() != 0) @(posedge clk);
        repeat (CLEAR_WAIT) @(posedge clk);
        if (mismatches == 0)
            $display("tb passed");
        else
            $display("tb failed");
        $finish;
    end
endmodule

// File: filelist.f
+incdir+design
design/mbp_pkg.sv
design/mbp_edge_if.sv
design/mbp_result_if.sv
design/mbp_ram.sv
design/max_bottleneck_path.sv
test/tb.sv
